>>> sv/schedule_completion_cost_engine_macros.svh
// ----------------------------------------------------------------------------
// Schedule completion cost engine assertion macros
// Shared concurrent check forms for the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef SCHEDULE_COMPLETION_COST_ENGINE_MACROS_SVH
`define SCHEDULE_COMPLETION_COST_ENGINE_MACROS_SVH

// same-cycle implication
`define SCCE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("schedule completion cost engine: check failed");

// next-cycle implication
`define SCCE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("schedule completion cost engine: check failed");

`endif

>>> sv/scce_pkg.sv
// ----------------------------------------------------------------------------
// Schedule completion cost engine package
// Item kinds, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package scce_pkg;

    localparam int MACHINES_DEF     = 8;
    localparam int MAX_SEQUENCE_DEF = 32;
    localparam int JOBS_DEF         = 64;
    localparam int COST_BITS_DEF    = 16;

    localparam int JOB_W   = 7;
    localparam int TOTAL_W = 29;

    typedef enum logic [2:0] {
        KIND_LOAD_FIRST  = 3'd0,
        KIND_LOAD_TRANS  = 3'd1,
        KIND_CLEAR       = 3'd2,
        KIND_APPEND      = 3'd3,
        KIND_INTERCHANGE = 3'd4,
        KIND_REINSERT    = 3'd5,
        KIND_EVALUATE    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_INDEX = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SWAP_RB,
        ST_SWAP_WA,
        ST_SWAP_WB,
        ST_RI_READ,
        ST_RI_SRC_WR,
        ST_RI_DST_START,
        ST_RI_DST_WR,
        ST_RI_PUT,
        ST_EVAL,
        ST_EVAL_DRAIN,
        ST_RESP
    } state_t;

endpackage

>>> sv/scce_seq_mem.sv
// ----------------------------------------------------------------------------
// Job sequence memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scce_seq_mem #(
    parameter int MACHINES     = scce_pkg::MACHINES_DEF,
    parameter int MAX_SEQUENCE = scce_pkg::MAX_SEQUENCE_DEF,
    parameter int AW           = (MACHINES * MAX_SEQUENCE > 1) ?
                                 $clog2(MACHINES * MAX_SEQUENCE) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [scce_pkg::JOB_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [scce_pkg::JOB_W-1:0] rdata
);
    localparam int DEPTH = MACHINES * MAX_SEQUENCE;

    logic [scce_pkg::JOB_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/scce_cost_mem.sv
// ----------------------------------------------------------------------------
// Setup cost memories
// First-job cost table and job-to-job cost table, registered reads.
// ----------------------------------------------------------------------------
module scce_cost_mem #(
    parameter int JOBS      = scce_pkg::JOBS_DEF,
    parameter int COST_BITS = scce_pkg::COST_BITS_DEF,
    parameter int FC_AW     = (JOBS > 1) ? $clog2(JOBS) : 1,
    parameter int TC_AW     = (JOBS > 1) ? $clog2(JOBS * JOBS) : 1
) (
    input  logic                 aclk,
    input  logic                 fc_we,
    input  logic [FC_AW-1:0]     fc_waddr,
    input  logic [FC_AW-1:0]     fc_raddr,
    output logic [COST_BITS-1:0] fc_rdata,
    input  logic                 tc_we,
    input  logic [TC_AW-1:0]     tc_waddr,
    input  logic [TC_AW-1:0]     tc_raddr,
    output logic [COST_BITS-1:0] tc_rdata,
    input  logic [COST_BITS-1:0] wdata
);
    logic [COST_BITS-1:0] first_mem [JOBS];
    logic [COST_BITS-1:0] trans_mem [JOBS * JOBS];

    always_ff @(posedge aclk) begin
        if (fc_we) begin
            first_mem[fc_waddr] <= wdata;
        end
        fc_rdata <= first_mem[fc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tc_we) begin
            trans_mem[tc_waddr] <= wdata;
        end
        tc_rdata <= trans_mem[tc_raddr];
    end
endmodule

>>> sv/schedule_completion_cost_engine.sv
// Loads, clear, append and faulted items go from dispatch to response; interchange
// passes SWAP_RB/WA/WB. Reinsert: one shifted entry per cycle on the sequence port.
// Evaluate: while the current machine has jobs left, one sequence read per cycle feeds
// a two-stage cost lookup and running-sum accumulator.
// One item in flight; a new item is taken while a result waits in the output register.
// Reset (synchronous, active low) empties all sequences; cost tables keep contents.
// ----------------------------------------------------------------------------
// Schedule completion cost engine
// Sequencer over job sequence and setup cost memories.
// ----------------------------------------------------------------------------
`include "schedule_completion_cost_engine_macros.svh"

module schedule_completion_cost_engine #(
    parameter int MACHINES     = scce_pkg::MACHINES_DEF,
    parameter int MAX_SEQUENCE = scce_pkg::MAX_SEQUENCE_DEF,
    parameter int JOBS         = scce_pkg::JOBS_DEF,
    parameter int COST_BITS    = scce_pkg::COST_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [2:0]  s_source_machine,
    input  logic [4:0]  s_source_position,
    input  logic [2:0]  s_dest_machine,
    input  logic [5:0]  s_dest_position,
    input  logic [6:0]  s_job,
    input  logic [6:0]  s_prior_job,
    input  logic [15:0] s_cost,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [28:0] m_total_completion_time,
    output logic [1:0]  m_status
);
    localparam int JW     = scce_pkg::JOB_W;
    localparam int TW     = scce_pkg::TOTAL_W;
    localparam int DEPTH  = MACHINES * MAX_SEQUENCE;
    localparam int SEQ_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MIW    = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int MCW    = $clog2(MACHINES + 1);
    localparam int LW     = $clog2(MAX_SEQUENCE + 1);
    localparam int FC_AW  = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int TC_AW  = (JOBS > 1) ? $clog2(JOBS * JOBS) : 1;

    scce_pkg::state_t state_reg, state_next;

    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  sm_reg, sm_next;
    logic [4:0]  sp_reg, sp_next;
    logic [2:0]  dm_reg, dm_next;
    logic [5:0]  dp_reg, dp_next;
    logic [6:0]  job_reg, job_next;
    logic [6:0]  prior_reg, prior_next;
    logic [15:0] cost_reg, cost_next;

    logic [LW-1:0] len_reg [MACHINES];
    logic [LW-1:0] len_next [MACHINES];
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] slen_reg, slen_next;
    logic [LW-1:0] dlen_reg, dlen_next;
    logic [JW-1:0] v_reg, v_next;
    logic [1:0]    status_reg, status_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] acc_reg, acc_next;
    logic [MCW-1:0] mit_reg, mit_next;
    logic [LW-1:0]  iit_reg, iit_next;
    logic [JW-1:0]  prev_reg, prev_next;
    logic p1_valid_reg, p1_valid_next, p1_first_reg, p1_first_next;
    logic p2_valid_reg, p2_valid_next, p2_first_reg, p2_first_next;

    logic          m_valid_reg, m_valid_next;
    logic [TW-1:0] m_total_reg, m_total_next;
    logic [1:0]    m_status_reg, m_status_next;

    logic              seq_we;
    logic [SEQ_AW-1:0] seq_waddr, seq_raddr;
    logic [JW-1:0]     seq_wdata, seq_rdata;
    logic              fc_we, tc_we;
    logic [FC_AW-1:0]  fc_raddr;
    logic [TC_AW-1:0]  tc_waddr, tc_raddr;
    logic [COST_BITS-1:0] fc_rdata, tc_rdata;

    logic [MIW-1:0] sm_i, dm_i;
    logic           sm_ok, dm_ok;
    logic [LW-1:0]  len_s, len_d, ri_dlen, cur_len;
    logic [TW-1:0]  cost_ext;
    logic           in_eval;

    function automatic logic job_ok(input logic [JW-1:0] j);
        return (j != '0) && (j <= JOBS);
    endfunction

    function automatic logic [SEQ_AW-1:0] seq_addr(input logic [MIW-1:0] m,
                                                   input logic [LW-1:0] pos);
        return SEQ_AW'(m) * SEQ_AW'(MAX_SEQUENCE) + SEQ_AW'(pos);
    endfunction

    function automatic logic [TC_AW-1:0] tc_index(input logic [JW-1:0] r,
                                                  input logic [JW-1:0] c);
        return TC_AW'(FC_AW'(r - 1'b1)) * TC_AW'(JOBS) + TC_AW'(FC_AW'(c - 1'b1));
    endfunction

    scce_seq_mem #(
        .MACHINES     (MACHINES),
        .MAX_SEQUENCE (MAX_SEQUENCE),
        .AW           (SEQ_AW)
    ) u_seq_mem (
        .aclk  (aclk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    scce_cost_mem #(
        .JOBS      (JOBS),
        .COST_BITS (COST_BITS),
        .FC_AW     (FC_AW),
        .TC_AW     (TC_AW)
    ) u_cost_mem (
        .aclk     (aclk),
        .fc_we    (fc_we),
        .fc_waddr (FC_AW'(job_reg - 1'b1)),
        .fc_raddr (fc_raddr),
        .fc_rdata (fc_rdata),
        .tc_we    (tc_we),
        .tc_waddr (tc_waddr),
        .tc_raddr (tc_raddr),
        .tc_rdata (tc_rdata),
        .wdata    (COST_BITS'(cost_reg))
    );

    assign s_ready                 = (state_reg == scce_pkg::ST_IDLE);
    assign m_valid                 = m_valid_reg;
    assign m_total_completion_time = m_total_reg;
    assign m_status                = m_status_reg;

    assign sm_i    = MIW'(sm_reg);
    assign dm_i    = MIW'(dm_reg);
    assign sm_ok   = (sm_reg < MACHINES);
    assign dm_ok   = (dm_reg < MACHINES);
    assign len_s   = sm_ok ? len_reg[sm_i] : '0;
    assign len_d   = dm_ok ? len_reg[dm_i] : '0;
    assign ri_dlen = (sm_reg == dm_reg) ? len_s - 1'b1 : len_d;
    assign cur_len = len_reg[MIW'(mit_reg)];
    assign tc_waddr = tc_index(prior_reg, job_reg);
    assign fc_raddr = FC_AW'(seq_rdata - 1'b1);
    assign tc_raddr = tc_index(prev_reg, seq_rdata);
    assign cost_ext = p2_first_reg ? TW'(fc_rdata) : TW'(tc_rdata);
    assign in_eval  = (state_reg == scce_pkg::ST_EVAL) ||
                      (state_reg == scce_pkg::ST_EVAL_DRAIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= scce_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            for (int m = 0; m < MACHINES; m++) begin
                len_reg[m] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            len_reg      <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        sm_reg       <= sm_next;
        sp_reg       <= sp_next;
        dm_reg       <= dm_next;
        dp_reg       <= dp_next;
        job_reg      <= job_next;
        prior_reg    <= prior_next;
        cost_reg     <= cost_next;
        idx_reg      <= idx_next;
        slen_reg     <= slen_next;
        dlen_reg     <= dlen_next;
        v_reg        <= v_next;
        status_reg   <= status_next;
        total_reg    <= total_next;
        acc_reg      <= acc_next;
        mit_reg      <= mit_next;
        iit_reg      <= iit_next;
        prev_reg     <= prev_next;
        p1_first_reg <= p1_first_next;
        p2_first_reg <= p2_first_next;
        m_total_reg  <= m_total_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        sm_next       = sm_reg;
        sp_next       = sp_reg;
        dm_next       = dm_reg;
        dp_next       = dp_reg;
        job_next      = job_reg;
        prior_next    = prior_reg;
        cost_next     = cost_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        slen_next     = slen_reg;
        dlen_next     = dlen_reg;
        v_next        = v_reg;
        status_next   = status_reg;
        total_next    = total_reg;
        acc_next      = acc_reg;
        mit_next      = mit_reg;
        iit_next      = iit_reg;
        prev_next     = prev_reg;
        p1_valid_next = 1'b0;
        p1_first_next = 1'b0;
        p2_valid_next = p1_valid_reg;
        p2_first_next = p1_first_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_total_next  = m_total_reg;
        m_status_next = m_status_reg;
        seq_we        = 1'b0;
        seq_waddr     = '0;
        seq_wdata     = '0;
        seq_raddr     = '0;
        fc_we         = 1'b0;
        tc_we         = 1'b0;

        case (state_reg)
            scce_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    sm_next    = s_source_machine;
                    sp_next    = s_source_position;
                    dm_next    = s_dest_machine;
                    dp_next    = s_dest_position;
                    job_next   = s_job;
                    prior_next = s_prior_job;
                    cost_next  = s_cost;
                    state_next = scce_pkg::ST_DISPATCH;
                end
            end
            scce_pkg::ST_DISPATCH: begin
                total_next  = '0;
                status_next = scce_pkg::STATUS_OK;
                state_next  = scce_pkg::ST_RESP;
                case (kind_reg)
                    scce_pkg::KIND_LOAD_FIRST: begin
                        if (!job_ok(job_reg)) begin
                            status_next = scce_pkg::STATUS_INDEX;
                        end else begin
                            fc_we = 1'b1;
                        end
                    end
                    scce_pkg::KIND_LOAD_TRANS: begin
                        if (!job_ok(job_reg) || !job_ok(prior_reg)) begin
                            status_next = scce_pkg::STATUS_INDEX;
                        end else begin
                            tc_we = 1'b1;
                        end
                    end
                    scce_pkg::KIND_CLEAR: begin
                        for (int m = 0; m < MACHINES; m++) begin
                            len_next[m] = '0;
                        end
                    end
                    scce_pkg::KIND_APPEND: begin
                        if (!sm_ok || !job_ok(job_reg)) begin
                            status_next = scce_pkg::STATUS_INDEX;
                        end else if (len_s >= MAX_SEQUENCE) begin
                            status_next = scce_pkg::STATUS_FULL;
                        end else begin
                            seq_we         = 1'b1;
                            seq_waddr      = seq_addr(sm_i, len_s);
                            seq_wdata      = job_reg;
                            len_next[sm_i] = len_s + 1'b1;
                        end
                    end
                    scce_pkg::KIND_INTERCHANGE: begin
                        if (!sm_ok || !dm_ok || sp_reg >= len_s || dp_reg >= len_d) begin
                            status_next = scce_pkg::STATUS_INDEX;
                        end else begin
                            seq_raddr  = seq_addr(sm_i, LW'(sp_reg));
                            state_next = scce_pkg::ST_SWAP_RB;
                        end
                    end
                    scce_pkg::KIND_REINSERT: begin
                        if (!sm_ok || !dm_ok || sp_reg >= len_s || dp_reg > ri_dlen) begin
                            status_next = scce_pkg::STATUS_INDEX;
                        end else if (sm_reg != dm_reg && ri_dlen >= MAX_SEQUENCE) begin
                            status_next = scce_pkg::STATUS_FULL;
                        end else begin
                            seq_raddr  = seq_addr(sm_i, LW'(sp_reg));
                            idx_next   = LW'(sp_reg);
                            slen_next  = len_s;
                            dlen_next  = ri_dlen;
                            state_next = scce_pkg::ST_RI_READ;
                        end
                    end
                    scce_pkg::KIND_EVALUATE: begin
                        acc_next   = '0;
                        mit_next   = '0;
                        iit_next   = '0;
                        state_next = scce_pkg::ST_EVAL;
                    end
                    default: begin
                        status_next = scce_pkg::STATUS_INDEX;
                    end
                endcase
            end
            scce_pkg::ST_SWAP_RB: begin
                v_next     = seq_rdata;
                seq_raddr  = seq_addr(dm_i, LW'(dp_reg));
                state_next = scce_pkg::ST_SWAP_WA;
            end
            scce_pkg::ST_SWAP_WA: begin
                seq_we     = 1'b1;
                seq_waddr  = seq_addr(sm_i, LW'(sp_reg));
                seq_wdata  = seq_rdata;
                state_next = scce_pkg::ST_SWAP_WB;
            end
            scce_pkg::ST_SWAP_WB: begin
                seq_we     = 1'b1;
                seq_waddr  = seq_addr(dm_i, LW'(dp_reg));
                seq_wdata  = v_reg;
                state_next = scce_pkg::ST_RESP;
            end
            scce_pkg::ST_RI_READ: begin
                v_next = seq_rdata;
                if ((LW + 1)'(idx_reg) + 1'b1 < (LW + 1)'(slen_reg)) begin
                    seq_raddr  = seq_addr(sm_i, LW'(idx_reg + 1'b1));
                    state_next = scce_pkg::ST_RI_SRC_WR;
                end else begin
                    state_next = scce_pkg::ST_RI_DST_START;
                end
            end
            scce_pkg::ST_RI_SRC_WR: begin
                seq_we    = 1'b1;
                seq_waddr = seq_addr(sm_i, idx_reg);
                seq_wdata = seq_rdata;
                idx_next  = idx_reg + 1'b1;
                if ((LW + 1)'(idx_reg) + 2'd2 < (LW + 1)'(slen_reg)) begin
                    seq_raddr = seq_addr(sm_i, LW'(idx_reg + 2'd2));
                end else begin
                    state_next = scce_pkg::ST_RI_DST_START;
                end
            end
            scce_pkg::ST_RI_DST_START: begin
                idx_next = dlen_reg;
                if (dlen_reg > dp_reg) begin
                    seq_raddr  = seq_addr(dm_i, dlen_reg - 1'b1);
                    state_next = scce_pkg::ST_RI_DST_WR;
                end else begin
                    state_next = scce_pkg::ST_RI_PUT;
                end
            end
            scce_pkg::ST_RI_DST_WR: begin
                seq_we    = 1'b1;
                seq_waddr = seq_addr(dm_i, idx_reg);
                seq_wdata = seq_rdata;
                idx_next  = idx_reg - 1'b1;
                if (idx_reg - 1'b1 > dp_reg) begin
                    seq_raddr = seq_addr(dm_i, idx_reg - 2'd2);
                end else begin
                    state_next = scce_pkg::ST_RI_PUT;
                end
            end
            scce_pkg::ST_RI_PUT: begin
                seq_we    = 1'b1;
                seq_waddr = seq_addr(dm_i, LW'(dp_reg));
                seq_wdata = v_reg;
                if (sm_i != dm_i) begin
                    len_next[sm_i] = slen_reg - 1'b1;
                    len_next[dm_i] = dlen_reg + 1'b1;
                end
                state_next = scce_pkg::ST_RESP;
            end
            scce_pkg::ST_EVAL: begin
                if (mit_reg == MCW'(MACHINES)) begin
                    state_next = scce_pkg::ST_EVAL_DRAIN;
                end else if (iit_reg < cur_len) begin
                    seq_raddr     = seq_addr(MIW'(mit_reg), iit_reg);
                    p1_valid_next = 1'b1;
                    p1_first_next = (iit_reg == '0);
                    iit_next      = iit_reg + 1'b1;
                end else begin
                    mit_next = mit_reg + 1'b1;
                    iit_next = '0;
                end
            end
            scce_pkg::ST_EVAL_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = scce_pkg::ST_RESP;
                end
            end
            scce_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_total_next  = total_reg;
                    m_status_next = status_reg;
                    state_next    = scce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scce_pkg::ST_IDLE;
            end
        endcase

        // lookup stage: remember the job for the next transition row
        if (p1_valid_reg) begin
            prev_next = seq_rdata;
        end
        // accumulate stage: running prefix sum weights each cost by its tail length
        if (p2_valid_reg) begin
            acc_next   = p2_first_reg ? cost_ext : acc_reg + cost_ext;
            total_next = total_reg + acc_next;
        end
    end

    `SCCE_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SCCE_ASSERT_IMPL(a_len_bound, aclk, aresetn, 1'b1, len_reg[0] <= LW'(MAX_SEQUENCE))
    `SCCE_ASSERT_IMPL(a_no_write_in_eval, aclk, aresetn, seq_we, !in_eval)
    `SCCE_ASSERT_IMPL(a_pipe_in_eval, aclk, aresetn, p2_valid_reg, in_eval)

endmodule
